@@ src/assert_macros.svh @@
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/vpv_pkg.sv @@
// ----------------------------------------------------------------------------
// vpv_pkg
// Types and constants of the vertex projection and viewport unit.
// ----------------------------------------------------------------------------
package vpv_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int VIEW_W         = 15;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD_MODEL = 2'd0,
    KIND_LOAD_PROJ  = 2'd1,
    KIND_PROJECT    = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_VIEW_X = 2'd0,
    REG_VIEW_Y = 2'd1,
    REG_VIEW_W = 2'd2,
    REG_VIEW_H = 2'd3
  } reg_idx_t;

endpackage

@@ src/vertex_project_viewport_unit.sv @@
// Throughput: one item per cycle unless the output stalls; every stage, including
// each quotient bit of the restoring dividers, is its own pipeline register.
// Model loads apply at the input stage, projection loads two stages later; no result.
// Reset (synchronous, active low) clears valid bits, restores identity
// matrices and the default viewport of 640 by 480 at the origin.
// ----------------------------------------------------------------------------
// vertex_project_viewport_unit
// Model/projection transform, perspective divide and viewport mapping.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_project_viewport_unit #(
  parameter int FRAC_BITS  = vpv_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = vpv_pkg::WORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // element_index[3:0], element_value[35:4], obj_x[67:36], obj_y[99:68],
  // obj_z[131:100], zero fill
  input  logic [135:0] in_tdata,
  // kind[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // win_x[31:0], win_y[63:32], win_z[95:64]
  output logic [95:0]  out_tdata,
  // ok[0]
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;          // exact product width
  localparam int SW  = PW + 3;         // sum of four products
  localparam int NW  = W + F;          // dividend magnitude width
  localparam int DIVS = NW;            // one quotient bit per stage
  localparam int VW  = vpv_pkg::VIEW_W;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = W'(1) << F;
  localparam logic signed [W-1:0] HALF = W'(1) << (F - 1);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [W-1:0] sat_in(input logic [31:0] v);
    logic signed [47:0] e;
    e = 48'(signed'(v));
    if (e > 48'(WMAX)) return WMAX;
    if (e < 48'(WMIN)) return WMIN;
    return W'(e);
  endfunction

  // exact product shifted with truncation toward zero, saturated
  function automatic logic signed [W-1:0] qscale(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    logic          neg;
    neg = p[PW-1];
    m = neg ? PW'(-p) : PW'(p);
    s = m >> F;
    if (neg) begin
      if (s > PW'(WMAX) + PW'(1)) return WMIN;
      return W'(-$signed(s));
    end
    if (s > PW'(WMAX)) return WMAX;
    return W'(s);
  endfunction

  function automatic logic signed [W-1:0] sat_sum(input logic signed [SW-1:0] v);
    if (v > SW'(WMAX)) return WMAX;
    if (v < SW'(WMIN)) return WMIN;
    return W'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [VW-1:0] view_x_r, view_y_r;
  logic        [VW-1:0] view_w_r, view_h_r;
  logic                 cfg_wr;
  vpv_pkg::reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = vpv_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_x_r <= '0;
      view_y_r <= '0;
      view_w_r <= VW'(640);
      view_h_r <= VW'(480);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vpv_pkg::REG_VIEW_X: view_x_r <= cfg_pwdata[VW-1:0];
        vpv_pkg::REG_VIEW_Y: view_y_r <= cfg_pwdata[VW-1:0];
        vpv_pkg::REG_VIEW_W: view_w_r <= cfg_pwdata[VW-1:0];
        vpv_pkg::REG_VIEW_H: view_h_r <= cfg_pwdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vpv_pkg::REG_VIEW_X: cfg_prdata = 32'(signed'(view_x_r));
      vpv_pkg::REG_VIEW_Y: cfg_prdata = 32'(signed'(view_y_r));
      vpv_pkg::REG_VIEW_W: cfg_prdata = 32'(view_w_r);
      vpv_pkg::REG_VIEW_H: cfg_prdata = 32'(view_h_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: whole pipe moves when the output register can take data
  // --------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Stage 0: input register, matrix loads
  // --------------------------------------------------------------------------
  logic signed [W-1:0] mdl_r [16];
  logic signed [W-1:0] prj_r [16];
  logic                s0_v_r;
  logic signed [W-1:0] s0_p_r [3];
  vpv_pkg::kind_t      in_kind;
  logic [3:0]          in_idx;
  logic                in_acc;
  // projection loads trail by two stages to meet points at the projection read
  logic                pl_v_r   [2];
  logic [3:0]          pl_idx_r [2];
  logic signed [W-1:0] pl_val_r [2];

  assign in_kind = vpv_pkg::kind_t'(in_tuser);
  assign in_idx  = in_tdata[3:0];
  assign in_acc  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_v_r[0] <= 1'b0;
      pl_v_r[1] <= 1'b0;
    end else if (adv) begin
      pl_v_r[0] <= in_acc && (in_kind == vpv_pkg::KIND_LOAD_PROJ);
      pl_v_r[1] <= pl_v_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_idx_r[0] <= in_idx;
      pl_val_r[0] <= sat_in(in_tdata[35:4]);
      pl_idx_r[1] <= pl_idx_r[0];
      pl_val_r[1] <= pl_val_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mdl_r[i] <= (i % 5 == 0) ? ONE : '0;
        prj_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else begin
      if (in_acc && in_kind == vpv_pkg::KIND_LOAD_MODEL)
        mdl_r[in_idx] <= sat_in(in_tdata[35:4]);
      if (adv && pl_v_r[1]) prj_r[pl_idx_r[1]] <= pl_val_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s0_v_r <= 1'b0;
    else if (adv) s0_v_r <= in_tvalid && (in_kind == vpv_pkg::KIND_PROJECT);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p_r[0] <= sat_in(in_tdata[67:36]);
      s0_p_r[1] <= sat_in(in_tdata[99:68]);
      s0_p_r[2] <= sat_in(in_tdata[131:100]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1-4: model transform (products, scale, sum) then projection
  // --------------------------------------------------------------------------
  logic                s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [PW-1:0] s1_pr_r [16];
  logic signed [W-1:0]  s2_mv_r [4];
  logic signed [PW-1:0] s3_pr_r [16];
  logic signed [W-1:0]  s4_cl_r [4];
  logic signed [W-1:0]  s0_vec [4];
  logic signed [SW-1:0] acc1 [4];
  logic signed [SW-1:0] acc2 [4];

  always_comb begin
    s0_vec[0] = s0_p_r[0];
    s0_vec[1] = s0_p_r[1];
    s0_vec[2] = s0_p_r[2];
    s0_vec[3] = ONE;
    for (int r = 0; r < 4; r++) begin
      acc1[r] = '0;
      acc2[r] = '0;
      for (int c = 0; c < 4; c++) begin
        acc1[r] = acc1[r] + SW'(qscale(s1_pr_r[c*4+r]));
        acc2[r] = acc2[r] + SW'(qscale(s3_pr_r[c*4+r]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r; s2_v_r <= s1_v_r; s3_v_r <= s2_v_r; s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 16; i++) begin
        s1_pr_r[i] <= PW'(mdl_r[i]) * PW'(s0_vec[i/4]);
        s3_pr_r[i] <= PW'(prj_r[i]) * PW'(s2_mv_r[i/4]);
      end
      for (int r = 0; r < 4; r++) begin
        s2_mv_r[r] <= sat_sum(acc1[r]);
        s4_cl_r[r] <= sat_sum(acc2[r]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: one restoring step per stage for x, y and z
  // --------------------------------------------------------------------------
  logic            dv_v_r   [DIVS+1];
  logic            dv_ok_r  [DIVS+1];
  logic [2:0]      dv_neg_r [DIVS+1];
  logic [W-1:0]    dv_d_r   [DIVS+1];
  logic [NW-1:0]   dv_n_r   [DIVS+1][3];
  logic [W:0]      dv_rem_r [DIVS+1][3];
  logic [W:0]      rem_sh   [DIVS][3];

  always_comb begin
    for (int s = 0; s < DIVS; s++)
      for (int k = 0; k < 3; k++)
        rem_sh[s][k] = {dv_rem_r[s][k][W-1:0], dv_n_r[s][k][NW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIVS; s++) dv_v_r[s] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= s4_v_r;
      for (int s = 0; s < DIVS; s++) dv_v_r[s+1] <= dv_v_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_ok_r[0] <= (s4_cl_r[3] != '0);
      dv_d_r[0]  <= s4_cl_r[3][W-1] ? W'(-s4_cl_r[3]) : W'(s4_cl_r[3]);
      for (int k = 0; k < 3; k++) begin
        dv_neg_r[0][k] <= s4_cl_r[k][W-1] ^ s4_cl_r[3][W-1];
        // magnitude zero-extends, so the most negative word gives 2^(W-1)
        dv_n_r[0][k]   <= NW'($unsigned(s4_cl_r[k][W-1] ? -s4_cl_r[k] : s4_cl_r[k])) << F;
        dv_rem_r[0][k] <= '0;
      end
      for (int s = 0; s < DIVS; s++) begin
        dv_ok_r[s+1]  <= dv_ok_r[s];
        dv_d_r[s+1]   <= dv_d_r[s];
        dv_neg_r[s+1] <= dv_neg_r[s];
        for (int k = 0; k < 3; k++) begin
          // quotient bit enters the vacated low end of the dividend word
          if (rem_sh[s][k] >= {1'b0, dv_d_r[s]}) begin
            dv_rem_r[s+1][k] <= rem_sh[s][k] - {1'b0, dv_d_r[s]};
            dv_n_r[s+1][k]   <= {dv_n_r[s][k][NW-2:0], 1'b1};
          end else begin
            dv_rem_r[s+1][k] <= rem_sh[s][k];
            dv_n_r[s+1][k]   <= {dv_n_r[s][k][NW-2:0], 1'b0};
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Post stages: sign/saturate, 1+n, viewport product, offset
  // --------------------------------------------------------------------------
  logic                 p1_v_r, p2_v_r, p3_v_r;
  logic                 p1_ok_r, p2_ok_r, p3_ok_r;
  logic signed [W-1:0]  p1_n_r [3];
  logic signed [PW-1:0] p2_pr_r [3];
  logic signed [W+1:0]  p3_w_r [3];
  logic signed [W-1:0]  nq [3];
  logic signed [W-1:0]  onep [3];
  logic signed [W-1:0]  scl [3];
  logic signed [W-1:0]  offs [2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_neg_r[DIVS][k])
        nq[k] = (dv_n_r[DIVS][k] > NW'(WMAX) + NW'(1)) ? WMIN
              : W'(-$signed({1'b0, dv_n_r[DIVS][k]}));
      else
        nq[k] = (dv_n_r[DIVS][k] > NW'(WMAX)) ? WMAX : W'(dv_n_r[DIVS][k]);
      onep[k] = sat_sum(SW'(p1_n_r[k]) + SW'(ONE));
    end
    scl[0] = W'(view_w_r) << (F - 1);
    scl[1] = W'(view_h_r) << (F - 1);
    scl[2] = HALF;
    offs[0] = W'(view_x_r) << F;
    offs[1] = W'(view_y_r) << F;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0; p2_v_r <= 1'b0; p3_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= dv_v_r[DIVS]; p2_v_r <= p1_v_r; p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ok_r <= dv_ok_r[DIVS];
      p2_ok_r <= p1_ok_r;
      p3_ok_r <= p2_ok_r;
      for (int k = 0; k < 3; k++) begin
        p1_n_r[k]  <= nq[k];
        p2_pr_r[k] <= PW'(onep[k]) * PW'(scl[k]);
      end
      p3_w_r[0] <= (W+2)'(qscale(p2_pr_r[0])) + (W+2)'(offs[0]);
      p3_w_r[1] <= (W+2)'(qscale(p2_pr_r[1])) + (W+2)'(offs[1]);
      p3_w_r[2] <= (W+2)'(qscale(p2_pr_r[2]));
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic signed [W-1:0] res [3];
  logic [95:0]         out_data_r;
  logic                out_ok_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!p3_ok_r) res[k] = '0;
      else if (p3_w_r[k] > (W+2)'(WMAX)) res[k] = WMAX;
      else if (p3_w_r[k] < (W+2)'(WMIN)) res[k] = WMIN;
      else res[k] = W'(p3_w_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= p3_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok_r   <= p3_ok_r;
      out_data_r <= {32'(res[2]), 32'(res[1]), 32'(res[0])};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `ASSERT_CLK(a_fail_zero, clk, rst_n, !out_tvalid || out_tuser || out_tdata == '0, "failed result not zero")
  `ASSERT_CLK(a_ready, clk, rst_n, in_tready == (!out_tvalid || out_tready), "ready mismatch")

endmodule
